FILE: sv/mefr_pkg.sv
package mefr_pkg;

    localparam int RX_W  = 5;
    localparam int BYTE_W = 8;

    // command codes
    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_MOUNT   = 2'd1;
    localparam logic [1:0] CMD_UNMOUNT = 2'd2;

    // lowest code index that carries a MIDI message
    localparam logic [3:0] CIN_MIN = 4'h2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              present;
        logic [RX_W-1:0]   rx_limit;
        logic [BYTE_W-1:0] tx_limit;
    } t_slot_rec;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        device;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] data_one;
        logic [BYTE_W-1:0] data_two;
        logic [BYTE_W-1:0] data_three;
        logic [BYTE_W-1:0] rx_cable_cnt;
        logic [BYTE_W-1:0] tx_cable_cnt;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        dest_device;
        logic [BYTE_W-1:0] out_header;
        logic [BYTE_W-1:0] out_data_one;
        logic [BYTE_W-1:0] out_data_two;
        logic [BYTE_W-1:0] out_data_three;
        logic              last;
    } t_out_beat;

endpackage

FILE: sv/midi_event_fanout_router.sv
// Mount and unmount beats write the slot table; the block is ready again right after.
// A packet beat looks up its source slot, checks it, and walks every slot
// through one shared compare unit, then sends one copy per cycle into the output register
// while that register is free; input is held off until the packet is done.
// Reset (synchronous, active low) unmounts every slot and empties the output register.
module midi_event_fanout_router #(
    parameter int SLOTS = 4,
    parameter int CABLE_LIMIT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mefr_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mefr_pkg::t_out_beat  o_out
);

    localparam int IDXW = $clog2(SLOTS);

    logic                wr_en;
    logic [IDXW-1:0]     wr_idx;
    mefr_pkg::t_slot_rec wr_rec;
    logic [IDXW-1:0]     rd_idx;
    mefr_pkg::t_slot_rec rd_rec;

    mefr_slot_table #(
        .SLOTS(SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (wr_en),
        .i_wr_idx(wr_idx),
        .i_wr_rec(wr_rec),
        .i_rd_idx(rd_idx),
        .o_rd_rec(rd_rec)
    );

    mefr_seq #(
        .SLOTS      (SLOTS),
        .CABLE_LIMIT(CABLE_LIMIT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .o_wr_en    (wr_en),
        .o_wr_idx   (wr_idx),
        .o_wr_rec   (wr_rec),
        .o_rd_idx   (rd_idx),
        .i_rd_rec   (rd_rec)
    );

endmodule

FILE: sv/mefr_slot_table.sv
module mefr_slot_table #(
    parameter int SLOTS = 4,
    localparam int IDXW = $clog2(SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [IDXW-1:0]      i_wr_idx,
    input  mefr_pkg::t_slot_rec  i_wr_rec,
    input  logic [IDXW-1:0]      i_rd_idx,
    output mefr_pkg::t_slot_rec  o_rd_rec
);

    logic [SLOTS-1:0]                  r_present;
    logic [mefr_pkg::RX_W-1:0]         r_rx [SLOTS];
    logic [mefr_pkg::BYTE_W-1:0]       r_tx [SLOTS];
    mefr_pkg::t_slot_rec               r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_wr_en) begin
            r_present[i_wr_idx] <= i_wr_rec.present;
        end
    end

    // limits are only looked at while the present bit is set
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rx[i_wr_idx] <= i_wr_rec.rx_limit;
            r_tx[i_wr_idx] <= i_wr_rec.tx_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rec.present  <= r_present[i_rd_idx];
        r_rd_rec.rx_limit <= r_rx[i_rd_idx];
        r_rd_rec.tx_limit <= r_tx[i_rd_idx];
    end

    assign o_rd_rec = r_rd_rec;

endmodule

FILE: sv/mefr_seq.sv
module mefr_seq #(
    parameter int SLOTS = 4,
    parameter int CABLE_LIMIT = 16,
    localparam int IDXW = $clog2(SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mefr_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mefr_pkg::t_out_beat  o_out,
    output logic                 o_wr_en,
    output logic [IDXW-1:0]      o_wr_idx,
    output mefr_pkg::t_slot_rec  o_wr_rec,
    output logic [IDXW-1:0]      o_rd_idx,
    input  mefr_pkg::t_slot_rec  i_rd_rec
);

    mefr_pkg::t_state    r_state, n_state;
    mefr_pkg::t_in_beat  r_item, n_item;
    logic [IDXW-1:0]     r_dev, n_dev;
    logic [IDXW-1:0]     r_scan, n_scan;
    logic [SLOTS-1:0]    r_mask, n_mask;
    logic                r_out_valid, n_out_valid;
    mefr_pkg::t_out_beat r_out, n_out;

    logic                in_acc;
    logic                dev_ok;
    logic [3:0]          cable;
    logic [3:0]          cin;
    logic [7:0]          cmp_lim;
    logic                cable_below;
    logic                src_ok;
    logic                hit;
    logic                scan_end;
    logic [IDXW-1:0]     first_idx;
    logic [SLOTS-1:0]    rest;
    logic                out_free;
    logic [mefr_pkg::RX_W-1:0] rx_clamp;

    assign in_acc   = i_in_valid && (r_state == mefr_pkg::ST_IDLE);
    assign dev_ok   = 32'(i_in.device) < SLOTS;
    assign cable    = r_item.header[7:4];
    assign cin      = r_item.header[3:0];
    assign rx_clamp = (32'(i_in.rx_cable_cnt) > CABLE_LIMIT)
                      ? mefr_pkg::RX_W'(CABLE_LIMIT)
                      : mefr_pkg::RX_W'(i_in.rx_cable_cnt);

    // single compare unit: source rx limit in CHECK, each slot's tx limit in SCAN
    assign cmp_lim     = (r_state == mefr_pkg::ST_CHECK) ? 8'(i_rd_rec.rx_limit)
                                                         : i_rd_rec.tx_limit;
    assign cable_below = {4'b0, cable} < cmp_lim;

    assign src_ok   = i_rd_rec.present && (cin >= mefr_pkg::CIN_MIN)
                      && (32'(cable) < CABLE_LIMIT) && cable_below;
    assign hit      = i_rd_rec.present && (r_scan != r_dev) && cable_below;
    assign scan_end = 32'(r_scan) == SLOTS - 1;
    assign out_free = !r_out_valid || i_out_ready;

    // lowest pending destination
    always_comb begin
        first_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) first_idx = IDXW'(s);
        end
        rest = r_mask;
        rest[first_idx] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mefr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_dev  <= n_dev;
        r_scan <= n_scan;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_dev       = r_dev;
        n_scan      = r_scan;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_wr_en     = 1'b0;
        o_wr_idx    = IDXW'(i_in.device);
        o_wr_rec    = '0;
        o_rd_idx    = r_dev;

        unique case (r_state)
            mefr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_item = i_in;
                    n_dev  = IDXW'(i_in.device);
                    if (dev_ok) begin
                        case (i_in.cmd)
                            mefr_pkg::CMD_MOUNT: begin
                                o_wr_en           = 1'b1;
                                o_wr_rec.present  = 1'b1;
                                o_wr_rec.rx_limit = rx_clamp;
                                o_wr_rec.tx_limit = i_in.tx_cable_cnt;
                            end
                            mefr_pkg::CMD_UNMOUNT: begin
                                o_wr_en = 1'b1;
                            end
                            mefr_pkg::CMD_PACKET: begin
                                n_state = mefr_pkg::ST_LOOKUP;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            mefr_pkg::ST_LOOKUP: begin
                n_state = mefr_pkg::ST_CHECK;
            end
            mefr_pkg::ST_CHECK: begin
                o_rd_idx = '0;
                n_scan   = '0;
                n_mask   = '0;
                n_state  = src_ok ? mefr_pkg::ST_SCAN : mefr_pkg::ST_IDLE;
            end
            mefr_pkg::ST_SCAN: begin
                n_mask[r_scan] = hit;
                o_rd_idx       = IDXW'(32'(r_scan) + 1);
                if (scan_end) begin
                    n_state = (n_mask == '0) ? mefr_pkg::ST_IDLE : mefr_pkg::ST_EMIT;
                end else begin
                    n_scan = IDXW'(32'(r_scan) + 1);
                end
            end
            mefr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.dest_device    = 2'(first_idx);
                    n_out.out_header     = r_item.header;
                    n_out.out_data_one   = r_item.data_one;
                    n_out.out_data_two   = r_item.data_two;
                    n_out.out_data_three = r_item.data_three;
                    n_out.last           = (rest == '0);
                    n_mask               = rest;
                    if (rest == '0) n_state = mefr_pkg::ST_IDLE;
                end
            end
            default: n_state = mefr_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == mefr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sv/mefr_checker.sv
module mefr_checker #(
    parameter int SLOTS = 4
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mefr_pkg::t_in_beat  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mefr_pkg::t_out_beat o_out
);

    logic in_acc;
    logic pkt_acc;
    logic ctl_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign pkt_acc = in_acc && (i_in.cmd == mefr_pkg::CMD_PACKET)
                     && (32'(i_in.device) < SLOTS);
    assign ctl_acc = in_acc && (i_in.cmd != mefr_pkg::CMD_PACKET);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // a packet beat blocks the input while it is looked up
    a_pkt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_acc |=> !o_in_ready)
        else $error("input taken during packet lookup");

    // no copy can show up before the slot walk has started
    a_pkt_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_acc && !o_out_valid |=> !o_out_valid ##1 !o_out_valid ##1 !o_out_valid)
        else $error("copy emitted too early");

    // mount, unmount and reserved beats create no result
    a_ctl_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_acc && !o_out_valid |=> !o_out_valid)
        else $error("control beat produced a result");

endmodule

bind midi_event_fanout_router mefr_checker #(
    .SLOTS(SLOTS)
) u_mefr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);

FILE: tb/sv/midi_event_fanout_router_tb.sv
module midi_event_fanout_router_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 4;
    localparam int CABLE_LIMIT  = 16;
    localparam int MAX_COPIES   = 3;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam int RANDOM_BEATS = 345;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    mefr_pkg::t_in_beat  in_beat = '0;
    logic                out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    mefr_pkg::t_out_beat o_out;

    midi_event_fanout_router #(
        .SLOTS(SLOTS),
        .CABLE_LIMIT(CABLE_LIMIT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in(in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out(o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // routing table as the block should hold it
    logic                        slot_present [SLOTS];
    logic [mefr_pkg::RX_W-1:0]   slot_rx_lim  [SLOTS];
    logic [mefr_pkg::BYTE_W-1:0] slot_tx_lim  [SLOTS];

    mefr_pkg::t_in_beat  beats_to_send [$];
    mefr_pkg::t_out_beat pending_copies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_at = 1 << 30;
    int hold_left = 0;
    logic hold_done = 1'b0;

    int accepted_cnt = 0;
    int copies_seen = 0;
    int packets_fanned = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_present[s] = 1'b0;
            slot_rx_lim[s]  = '0;
            slot_tx_lim[s]  = '0;
        end
    end

    function automatic void predict_copies(input mefr_pkg::t_in_beat b);
        int cable;
        int hits[$];
        mefr_pkg::t_out_beat c;
        case (b.cmd)
            mefr_pkg::CMD_MOUNT: begin
                slot_present[b.device] = 1'b1;
                slot_rx_lim[b.device]  = (b.rx_cable_cnt > CABLE_LIMIT) ?
                                         mefr_pkg::RX_W'(CABLE_LIMIT) :
                                         b.rx_cable_cnt[mefr_pkg::RX_W-1:0];
                slot_tx_lim[b.device]  = b.tx_cable_cnt;
            end
            mefr_pkg::CMD_UNMOUNT: begin
                slot_present[b.device] = 1'b0;
                slot_rx_lim[b.device]  = '0;
                slot_tx_lim[b.device]  = '0;
            end
            mefr_pkg::CMD_PACKET: begin
                cable = int'(b.header[7:4]);
                if (slot_present[b.device] && b.header[3:0] >= mefr_pkg::CIN_MIN &&
                    cable < CABLE_LIMIT && cable < int'(slot_rx_lim[b.device])) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (s != int'(b.device) && slot_present[s] &&
                            cable < int'(slot_tx_lim[s]) && hits.size() < MAX_COPIES)
                            hits.push_back(s);
                    end
                    if (hits.size() > 0)
                        packets_fanned++;
                    foreach (hits[k]) begin
                        c.dest_device    = 2'(hits[k]);
                        c.out_header     = b.header;
                        c.out_data_one   = b.data_one;
                        c.out_data_two   = b.data_two;
                        c.out_data_three = b.data_three;
                        c.last           = (k == hits.size() - 1);
                        pending_copies.push_back(c);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic mefr_pkg::t_in_beat packet_beat(input logic [1:0] dev,
                                                       input logic [7:0] hdr,
                                                       input logic [7:0] d1,
                                                       input logic [7:0] d2,
                                                       input logic [7:0] d3);
        mefr_pkg::t_in_beat b;
        b = '0;
        b.cmd        = mefr_pkg::CMD_PACKET;
        b.device     = dev;
        b.header     = hdr;
        b.data_one   = d1;
        b.data_two   = d2;
        b.data_three = d3;
        return b;
    endfunction

    function automatic mefr_pkg::t_in_beat slot_beat(input logic [1:0] cmd,
                                                     input logic [1:0] dev,
                                                     input logic [7:0] rx,
                                                     input logic [7:0] tx);
        mefr_pkg::t_in_beat b;
        b = '0;
        b.cmd          = cmd;
        b.device       = dev;
        b.rx_cable_cnt = rx;
        b.tx_cable_cnt = tx;
        return b;
    endfunction

    // mostly sane mounts and routable packets; the rest is full-range noise
    function automatic mefr_pkg::t_in_beat random_beat();
        mefr_pkg::t_in_beat b;
        int pick;
        b.cmd    = 2'($urandom_range(0, 3));
        b.device = 2'($urandom_range(0, 3));
        {b.header, b.data_one, b.data_two, b.data_three} = $urandom;
        {b.rx_cable_cnt, b.tx_cable_cnt} = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            b.cmd = mefr_pkg::CMD_MOUNT;
            if ($urandom_range(0, 3) != 0) begin
                b.rx_cable_cnt = 8'($urandom_range(0, 17));
                b.tx_cable_cnt = 8'($urandom_range(0, 17));
            end
        end else if (pick < 21) begin
            b.cmd = mefr_pkg::CMD_UNMOUNT;
        end else if (pick < 24) begin
            b.cmd = CMD_RESERVED;
        end else begin
            b.cmd = mefr_pkg::CMD_PACKET;
            if ($urandom_range(0, 4) != 0)
                b.header = {4'($urandom_range(0, 3)), 4'($urandom_range(2, 15))};
        end
        return b;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (beats_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= beats_to_send.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            predict_copies(in_beat);
            accepted_cnt++;
        end
    end

    // long receiver hold-off so the output register fills and input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // output checker
    always @(posedge i_clk) begin
        mefr_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && out_ready) begin
            copies_seen++;
            if (pending_copies.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: dest=%0d hdr=%h data=%h %h %h last=%0d",
                             o_out.dest_device, o_out.out_header, o_out.out_data_one,
                             o_out.out_data_two, o_out.out_data_three, o_out.last);
            end else begin
                want = pending_copies.pop_front();
                if (o_out.dest_device !== want.dest_device ||
                    o_out.out_header !== want.out_header ||
                    o_out.out_data_one !== want.out_data_one ||
                    o_out.out_data_two !== want.out_data_two ||
                    o_out.out_data_three !== want.out_data_three ||
                    o_out.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"copy mismatch: exp dest=%0d hdr=%h data=%h %h %h last=%0d",
                                  " | got dest=%0d hdr=%h data=%h %h %h last=%0d"},
                                 want.dest_device, want.out_header, want.out_data_one,
                                 want.out_data_two, want.out_data_three, want.last,
                                 o_out.dest_device, o_out.out_header, o_out.out_data_one,
                                 o_out.out_data_two, o_out.out_data_three, o_out.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d copies still owed",
                     cycle_cnt, pending_copies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int chunk;
        // directed: routing table corners and each reachable drop rule
        beats_to_send.push_back(packet_beat(2'd0, 8'h12, 8'h00, 8'h00, 8'h00));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd0, 8'hFF, 8'hFF));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd1, 8'h00, 8'h00));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd2, 8'd3, 8'd2));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd3, 8'd16, 8'd16));
        beats_to_send.push_back(packet_beat(2'd0, 8'hF2, 8'hFF, 8'hFF, 8'hFF));
        beats_to_send.push_back(packet_beat(2'd0, 8'h0F, 8'h00, 8'hFF, 8'h00));
        beats_to_send.push_back(packet_beat(2'd0, 8'h01, 8'hAA, 8'h55, 8'hAA));
        beats_to_send.push_back(packet_beat(2'd0, 8'h00, 8'h55, 8'hAA, 8'h55));
        beats_to_send.push_back(packet_beat(2'd1, 8'h02, 8'h11, 8'h22, 8'h33));
        beats_to_send.push_back(packet_beat(2'd2, 8'h22, 8'hAA, 8'h55, 8'hAA));
        beats_to_send.push_back(packet_beat(2'd2, 8'h32, 8'h01, 8'h02, 8'h03));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd1, 8'd20, 8'd200));
        beats_to_send.push_back(packet_beat(2'd3, 8'h12, 8'h55, 8'hAA, 8'h55));
        beats_to_send.push_back(packet_beat(2'd3, 8'hF2, 8'h80, 8'h7F, 8'h01));
        beats_to_send.push_back(slot_beat(CMD_RESERVED, 2'd0, 8'hFF, 8'hFF));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_UNMOUNT, 2'd2, 8'h00, 8'h00));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_UNMOUNT, 2'd2, 8'hFF, 8'hFF));
        beats_to_send.push_back(packet_beat(2'd2, 8'h22, 8'h12, 8'h34, 8'h56));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_UNMOUNT, 2'd1, 8'h00, 8'h00));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_UNMOUNT, 2'd3, 8'h00, 8'h00));
        beats_to_send.push_back(packet_beat(2'd0, 8'h02, 8'h9A, 8'hBC, 8'hDE));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_MOUNT, 2'd1, 8'd17, 8'd0));
        beats_to_send.push_back(packet_beat(2'd1, 8'hF5, 8'hFE, 8'hDC, 8'hBA));
        beats_to_send.push_back(slot_beat(mefr_pkg::CMD_UNMOUNT, 2'd0, 8'h00, 8'h00));

        chunk = RANDOM_BEATS / 3;
        repeat (chunk) beats_to_send.push_back(random_beat());

        send_idle_pct = 13;
        recv_idle_pct = 48;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            while (beats_to_send.size() > 0 || in_valid)
                @(posedge i_clk);
            if (phase == 0) begin
                send_idle_pct = 48;
                recv_idle_pct = 13;
                repeat (chunk) beats_to_send.push_back(random_beat());
            end else if (phase == 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_at = accepted_cnt + 20;
                repeat (RANDOM_BEATS - 2 * chunk) beats_to_send.push_back(random_beat());
            end
        end

        while (pending_copies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d beats; %0d packets fanned out into %0d checked copies",
                 accepted_cnt, packets_fanned, copies_seen);
        $display("covered mount/unmount churn, drop rules, and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (err_cnt == 0 && pending_copies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d copies never arrived", err_cnt, pending_copies.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: midi_event_fanout_router.f
sv/mefr_pkg.sv
sv/mefr_slot_table.sv
sv/mefr_seq.sv
sv/midi_event_fanout_router.sv
sv/mefr_checker.sv
tb/sv/midi_event_fanout_router_tb.sv
